>>> rtl/assert_macros.svh
// Assertion macros for the checker file of the key detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KEPD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("key detector assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KEPD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("key detector assertion failed");

`endif

>>> rtl/kepd_pkg.sv
// Package with widths, codes, reset values and types of the key detector.
`default_nettype none

package kepd_pkg;

    // Field widths.
    localparam int OP_W      = 3;
    localparam int SAMPLE_W  = 10;
    localparam int TIME_W    = 32;
    localparam int MODE_W    = 2;
    localparam int LONG_W    = 16;
    localparam int STATE_W   = 2;
    localparam int EVENT_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLASSIFY  = 3'd0;
    localparam logic [OP_W-1:0] OP_ASK_REL   = 3'd1;
    localparam logic [OP_W-1:0] OP_ASK_PRSNG = 3'd2;
    localparam logic [OP_W-1:0] OP_ASK_PRSD  = 3'd3;
    localparam logic [OP_W-1:0] OP_ASK_RLSNG = 3'd4;
    localparam logic [OP_W-1:0] OP_EVENT     = 3'd5;

    // Key state codes.
    localparam logic [STATE_W-1:0] KS_RELEASED  = 2'd0;
    localparam logic [STATE_W-1:0] KS_PRESSING  = 2'd1;
    localparam logic [STATE_W-1:0] KS_PRESSED   = 2'd2;
    localparam logic [STATE_W-1:0] KS_RELEASING = 2'd3;

    // Press event codes.
    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SHORT = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LONG  = 2'd2;

    // Sense modes; any other code selects the analog window.
    localparam logic [MODE_W-1:0] MODE_DIRECT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INVERTED = 2'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SENSE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 2'd3;

    // Configuration reset values.
    localparam logic [MODE_W-1:0]   RST_SENSE_MODE  = MODE_DIRECT;
    localparam logic [SAMPLE_W-1:0] RST_WINDOW_LOW  = 10'd0;
    localparam logic [SAMPLE_W-1:0] RST_WINDOW_HIGH = 10'd1023;
    localparam logic [LONG_W-1:0]   RST_LONG_PRESS  = 16'd1000;

    // One input beat.
    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [SAMPLE_W-1:0] key_sample;
        logic [TIME_W-1:0]   now_ms;
    } kepd_item_t;

    // One result beat.
    typedef struct packed {
        logic [STATE_W-1:0] key_state;
        logic               query_hit;
        logic [EVENT_W-1:0] press_event;
    } kepd_result_t;

    // Configuration register set.
    typedef struct packed {
        logic [MODE_W-1:0]   sense_mode;
        logic [SAMPLE_W-1:0] window_low;
        logic [SAMPLE_W-1:0] window_high;
        logic [LONG_W-1:0]   long_press_ms;
    } kepd_cfg_t;

endpackage

`default_nettype wire

>>> rtl/kepd_if.sv
// Valid/ready stream interfaces for the key detector input and result channels.
`default_nettype none

interface kepd_in_if;
    import kepd_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [SAMPLE_W-1:0] key_sample;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, output operation, output key_sample, output now_ms,
                    input ready);
    modport sink   (input valid, input operation, input key_sample, input now_ms,
                    output ready);
endinterface

interface kepd_out_if;
    import kepd_pkg::*;

    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] key_state;
    logic               query_hit;
    logic [EVENT_W-1:0] press_event;

    modport source (output valid, output key_state, output query_hit, output press_event,
                    input ready);
    modport sink   (input valid, input key_state, input query_hit, input press_event,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/kepd_level.sv
// Turns a raw key sample into the one-bit active level for the selected sense mode.
`default_nettype none

module kepd_level (
    input  wire logic [kepd_pkg::SAMPLE_W-1:0] key_sample,
    input  wire kepd_pkg::kepd_cfg_t           cfg,
    output logic                               level
);
    import kepd_pkg::*;

    logic in_window;

    // Analog window: low bound inclusive, high bound exclusive.
    assign in_window = (key_sample >= cfg.window_low) && (key_sample < cfg.window_high);

    always_comb
    begin
        case (cfg.sense_mode)
            MODE_DIRECT:   level = key_sample[0];
            MODE_INVERTED: level = ~key_sample[0];
            default:       level = in_window;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/kepd_core.sv
// Edge classification, latched query flags and press timing with their state registers.
`default_nettype none

module kepd_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire kepd_pkg::kepd_item_t   item,
    input  wire kepd_pkg::kepd_cfg_t    cfg,
    output kepd_pkg::kepd_result_t      result
);
    import kepd_pkg::*;

    logic              prev_level_reg;
    logic              held_reg;
    logic              held_next;
    logic              press_latched_reg;
    logic              press_latched_next;
    logic              release_latched_reg;
    logic              release_latched_next;
    logic              down_armed_reg;
    logic              down_armed_next;
    logic [TIME_W-1:0] press_stamp_reg;
    logic [TIME_W-1:0] press_stamp_next;

    logic               cur_level;
    logic [STATE_W-1:0] key_state;
    logic [TIME_W-1:0]  stamp_now;
    logic [TIME_W-1:0]  elapsed;
    logic               is_long;
    logic               held_upd;
    logic               press_upd;
    logic               release_upd;
    logic               hit;
    logic [EVENT_W-1:0] event_code;

    kepd_level u_level (
        .key_sample (item.key_sample),
        .cfg        (cfg),
        .level      (cur_level)
    );

    // Key state from the previous and the new level.
    always_comb
    begin
        case ({prev_level_reg, cur_level})
            2'b01:   key_state = KS_PRESSING;
            2'b10:   key_state = KS_RELEASING;
            2'b11:   key_state = KS_PRESSED;
            default: key_state = KS_RELEASED;
        endcase
    end

    // A pressing edge restamps before the elapsed time is measured.
    assign stamp_now = (key_state == KS_PRESSING) ? item.now_ms : press_stamp_reg;
    assign elapsed   = item.now_ms - stamp_now;
    assign is_long   = elapsed > {{(TIME_W-LONG_W){1'b0}}, cfg.long_press_ms};

    // Flag updates for the query path, before the query reads them.
    always_comb
    begin
        held_upd        = held_reg;
        press_upd       = press_latched_reg;
        release_upd     = release_latched_reg;
        down_armed_next = down_armed_reg;
        case (key_state)
            KS_PRESSING:
            begin
                if (!down_armed_reg)
                begin
                    press_upd       = 1'b1;
                    down_armed_next = 1'b1;
                end
            end
            KS_RELEASING:
            begin
                if (down_armed_reg)
                begin
                    release_upd     = 1'b1;
                    down_armed_next = 1'b0;
                end
            end
            KS_RELEASED: held_upd = 1'b0;
            default:     held_upd = 1'b1;
        endcase
    end

    // Operation dispatch: classify, press event, or query (undefined codes act as a query).
    always_comb
    begin
        held_next            = held_reg;
        press_latched_next   = press_latched_reg;
        release_latched_next = release_latched_reg;
        press_stamp_next     = press_stamp_reg;
        hit                  = 1'b0;
        event_code           = EV_NONE;
        case (item.operation)
            OP_CLASSIFY:
            begin
            end
            OP_EVENT:
            begin
                press_stamp_next = stamp_now;
                if (is_long)
                begin
                    if ((key_state == KS_PRESSING) || (key_state == KS_PRESSED))
                        event_code = EV_LONG;
                end
                else if (key_state == KS_RELEASING)
                begin
                    press_stamp_next = '0;
                    event_code       = EV_SHORT;
                end
            end
            default:
            begin
                held_next            = held_upd;
                press_latched_next   = press_upd;
                release_latched_next = release_upd;
                case (item.operation)
                    OP_ASK_REL:   hit = !held_upd && !cur_level;
                    OP_ASK_PRSNG:
                    begin
                        hit                = press_upd;
                        press_latched_next = 1'b0;
                    end
                    OP_ASK_PRSD:  hit = held_upd && cur_level;
                    OP_ASK_RLSNG:
                    begin
                        hit                  = release_upd;
                        release_latched_next = 1'b0;
                    end
                    default:      hit = 1'b0;
                endcase
            end
        endcase
    end

    // State registers advance once per item handed to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg      <= 1'b0;
            held_reg            <= 1'b0;
            press_latched_reg   <= 1'b0;
            release_latched_reg <= 1'b0;
            down_armed_reg      <= 1'b0;
            press_stamp_reg     <= '0;
        end
        else if (advance)
        begin
            prev_level_reg <= cur_level;
            press_stamp_reg <= press_stamp_next;
            if (item.operation != OP_EVENT && item.operation != OP_CLASSIFY)
                down_armed_reg <= down_armed_next;
            held_reg            <= held_next;
            press_latched_reg   <= press_latched_next;
            release_latched_reg <= release_latched_next;
        end
    end

    assign result.key_state   = key_state;
    assign result.query_hit   = hit;
    assign result.press_event = event_code;

endmodule

`default_nettype wire

>>> rtl/key_edge_and_press_detector.sv
// Key edge and press detector: a registered item feeds one pass of logic into a result register.
// A beat accepted into the input register passes through the core logic into the result register.
// Throughput: one beat per cycle while the result side keeps reading; a stalled result holds the input.
// Input is taken while the result register holds an unread beat if the input stage is free.
// Reset clears all key state, both valid flags and the registers to their documented values.
`default_nettype none

module key_edge_and_press_detector (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    kepd_in_if.sink                              key_in,
    kepd_out_if.source                           result_out,
    input  wire logic                            cfg_we,
    input  wire logic [kepd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kepd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kepd_pkg::*;

    kepd_cfg_t    cfg_reg;
    logic         s1_valid_reg;
    logic         s1_valid_next;
    kepd_item_t   s1_item_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    kepd_result_t out_res_reg;
    kepd_result_t core_res;
    logic         out_free;
    logic         s1_move;
    logic         accept;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sense_mode    <= RST_SENSE_MODE;
            cfg_reg.window_low    <= RST_WINDOW_LOW;
            cfg_reg.window_high   <= RST_WINDOW_HIGH;
            cfg_reg.long_press_ms <= RST_LONG_PRESS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SENSE_MODE:  cfg_reg.sense_mode    <= cfg_data[MODE_W-1:0];
                CFG_WINDOW_LOW:  cfg_reg.window_low    <= cfg_data[SAMPLE_W-1:0];
                CFG_WINDOW_HIGH: cfg_reg.window_high   <= cfg_data[SAMPLE_W-1:0];
                CFG_LONG_PRESS:  cfg_reg.long_press_ms <= cfg_data[LONG_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Handshake: the input stage moves on when the result register is empty or being read.
    assign out_free     = !out_valid_reg || result_out.ready;
    assign s1_move      = s1_valid_reg && out_free;
    assign key_in.ready = !s1_valid_reg || out_free;
    assign accept       = key_in.valid && key_in.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_move)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.operation  <= key_in.operation;
            s1_item_reg.key_sample <= key_in.key_sample;
            s1_item_reg.now_ms     <= key_in.now_ms;
        end
    end

    kepd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_move),
        .item    (s1_item_reg),
        .cfg     (cfg_reg),
        .result  (core_res)
    );

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s1_move)
            out_res_reg <= core_res;
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.key_state   = out_res_reg.key_state;
    assign result_out.query_hit   = out_res_reg.query_hit;
    assign result_out.press_event = out_res_reg.press_event;

endmodule

`default_nettype wire

>>> rtl/kepd_checker.sv
// Port-level checker for the key detector and the bind that attaches it.
`default_nettype none
`include "assert_macros.svh"

module kepd_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [kepd_pkg::STATE_W-1:0]     out_key_state,
    input wire logic                             out_query_hit,
    input wire logic [kepd_pkg::EVENT_W-1:0]     out_press_event
);
    import kepd_pkg::*;

    // A stalled result beat holds its value.
    `KEPD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_key_state) && $stable(out_query_hit) && $stable(out_press_event))

    // A query answer and a press event never come from the same beat.
    `KEPD_ASSERT_IMP(a_hit_event_excl, clk, rst_n, out_valid && out_query_hit, out_press_event == EV_NONE)

    // A long press is only reported while the key stays down.
    `KEPD_ASSERT_IMP(a_long_held, clk, rst_n, out_valid && (out_press_event == EV_LONG), out_key_state == KS_PRESSED)

    // A short press is only reported on a releasing edge.
    `KEPD_ASSERT_IMP(a_short_release, clk, rst_n, out_valid && (out_press_event == EV_SHORT), out_key_state == KS_RELEASING)

endmodule

bind key_edge_and_press_detector kepd_checker u_kepd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result_out.valid),
    .out_ready       (result_out.ready),
    .out_key_state   (result_out.key_state),
    .out_query_hit   (result_out.query_hit),
    .out_press_event (result_out.press_event)
);

`default_nettype wire

>>> tb/kepd_press_checker.sv
// Checker that predicts and compares the results of the key edge and press detector.
`timescale 1ns / 1ps

module kepd_press_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    kepd_in_if                              key_mon,
    kepd_out_if                             res_mon,
    input  logic                            cfg_we,
    input  logic [kepd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kepd_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending
);
    import kepd_pkg::*;

    // Shadow copy of the configuration registers.
    logic [MODE_W-1:0]   sense_mode;
    logic [SAMPLE_W-1:0] window_low;
    logic [SAMPLE_W-1:0] window_high;
    logic [LONG_W-1:0]   long_press_ms;

    // Shadow copy of the key state.
    logic              last_level;
    logic              held;
    logic              press_flag;
    logic              release_flag;
    logic              armed;
    logic [TIME_W-1:0] press_stamp;

    // Results still owed by the block, oldest first.
    kepd_result_t expected_results[$];

    // Turn a raw sample into the active level for the current sense mode.
    function automatic logic active_level(logic [SAMPLE_W-1:0] sample);
        case (sense_mode)
            MODE_DIRECT:   return sample[0];
            MODE_INVERTED: return ~sample[0];
            default:       return (sample >= window_low) && (sample < window_high);
        endcase
    endfunction

    // Work out the result of one input beat and advance the shadow state.
    function automatic kepd_result_t predict_key_result(kepd_item_t item);
        kepd_result_t      res;
        logic              cur;
        logic              old;
        logic [TIME_W-1:0] elapsed;

        old = last_level;
        cur = active_level(item.key_sample);
        last_level = cur;
        res.query_hit = 1'b0;
        res.press_event = EV_NONE;

        if (!old && cur)
            res.key_state = KS_PRESSING;
        else if (old && !cur)
            res.key_state = KS_RELEASING;
        else if (cur)
            res.key_state = KS_PRESSED;
        else
            res.key_state = KS_RELEASED;

        if (item.operation == OP_EVENT)
        begin
            // A pressing edge stamps the time before the elapsed test.
            if (res.key_state == KS_PRESSING)
                press_stamp = item.now_ms;
            elapsed = item.now_ms - press_stamp;
            if (elapsed > TIME_W'(long_press_ms))
            begin
                if (res.key_state == KS_PRESSING || res.key_state == KS_PRESSED)
                    res.press_event = EV_LONG;
            end
            else if (res.key_state == KS_RELEASING)
            begin
                press_stamp = '0;
                res.press_event = EV_SHORT;
            end
        end
        else if (item.operation != OP_CLASSIFY)
        begin
            // Queries and the spare codes update the latched flags.
            case (res.key_state)
                KS_PRESSING:
                begin
                    if (!armed)
                    begin
                        press_flag = 1'b1;
                        armed = 1'b1;
                    end
                end
                KS_RELEASING:
                begin
                    if (armed)
                    begin
                        release_flag = 1'b1;
                        armed = 1'b0;
                    end
                end
                KS_RELEASED: held = 1'b0;
                default:     held = 1'b1;
            endcase

            // Answer the query; press and release flags clear on read.
            if (item.operation == OP_ASK_REL && !held && !cur)
                res.query_hit = 1'b1;
            else if (item.operation == OP_ASK_PRSNG && press_flag)
            begin
                press_flag = 1'b0;
                res.query_hit = 1'b1;
            end
            else if (item.operation == OP_ASK_PRSD && held && cur)
                res.query_hit = 1'b1;
            else if (item.operation == OP_ASK_RLSNG && release_flag)
            begin
                release_flag = 1'b0;
                res.query_hit = 1'b1;
            end
        end
        return res;
    endfunction

    // Count a wrong field and print it.
    task automatic report_field(string field, int want, int got);
        fail_count++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    // Watch both channels and the register port at every edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        kepd_result_t want;
        kepd_result_t got;
        kepd_item_t   item;

        if (!rst_n)
        begin
            sense_mode    = RST_SENSE_MODE;
            window_low    = RST_WINDOW_LOW;
            window_high   = RST_WINDOW_HIGH;
            long_press_ms = RST_LONG_PRESS;
            last_level    = 1'b0;
            held          = 1'b0;
            press_flag    = 1'b0;
            release_flag  = 1'b0;
            armed         = 1'b0;
            press_stamp   = '0;
            expected_results.delete();
            fail_count    = 0;
            pending       = 0;
        end
        else
        begin
            // Register writes.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SENSE_MODE:  sense_mode    = cfg_data[MODE_W-1:0];
                    CFG_WINDOW_LOW:  window_low    = cfg_data[SAMPLE_W-1:0];
                    CFG_WINDOW_HIGH: window_high   = cfg_data[SAMPLE_W-1:0];
                    CFG_LONG_PRESS:  long_press_ms = cfg_data[LONG_W-1:0];
                    default: ;
                endcase
            end

            // Result beats are compared with the oldest expectation.
            if (res_mon.valid && res_mon.ready)
            begin
                got.key_state   = res_mon.key_state;
                got.query_hit   = res_mon.query_hit;
                got.press_event = res_mon.press_event;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.key_state !== want.key_state)
                        report_field("key_state", want.key_state, got.key_state);
                    if (got.query_hit !== want.query_hit)
                        report_field("query_hit", want.query_hit, got.query_hit);
                    if (got.press_event !== want.press_event)
                        report_field("press_event", want.press_event, got.press_event);
                end
            end

            // Input beats produce one expected result each.
            if (key_mon.valid && key_mon.ready)
            begin
                item.operation  = key_mon.operation;
                item.key_sample = key_mon.key_sample;
                item.now_ms     = key_mon.now_ms;
                expected_results.push_back(predict_key_result(item));
            end

            pending = expected_results.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// Top of the key edge and press detector testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import kepd_pkg::*;

    localparam int IDLE_LIMIT      = 1000;
    localparam int ITEMS_PER_PHASE = 88;

    // Codes the package leaves unnamed.
    localparam logic [MODE_W-1:0] MODE_WINDOW = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
    localparam logic [OP_W-1:0]   OP_SPARE_A  = 3'd6;
    localparam logic [OP_W-1:0]   OP_SPARE_B  = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles;

    // Stimulus-side copy of the configuration, used to aim the samples.
    logic [MODE_W-1:0]   cur_mode;
    logic [SAMPLE_W-1:0] cur_low;
    logic [SAMPLE_W-1:0] cur_high;
    logic [LONG_W-1:0]   cur_long;

    // Intended key level and running millisecond time of the random walk.
    logic              key_level;
    logic [TIME_W-1:0] clock_ms;
    bit                tx_burst;
    bit                rx_burst;

    kepd_in_if  key_in();
    kepd_out_if result_out();

    key_edge_and_press_detector u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_in     (key_in),
        .result_out (result_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    kepd_press_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_mon    (key_in),
        .res_mon    (result_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: end the run when no beat moves for too long.
    initial idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((key_in.valid && key_in.ready) || (result_out.valid && result_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("key_edge_and_press_detector: mismatch");
            $finish;
        end
    end

    // Result side: a random stall before each beat, with stall-free stretches.
    initial
    begin : result_sink
        int stall;

        result_out.ready <= 1'b0;
        rx_burst = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                result_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_out.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_out.valid && result_out.ready));
        end
    end

    // Offer one input beat after a random gap and wait until it is taken.
    // Valid stays high after the beat so that a back-to-back beat keeps it up.
    task automatic send(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] sample,
                        logic [TIME_W-1:0] now);
        int gap;

        if ($urandom_range(0, 31) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            key_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_in.valid      <= 1'b1;
        key_in.operation  <= op;
        key_in.key_sample <= sample;
        key_in.now_ms     <= now;
        do
            @(posedge clk);
        while (!(key_in.valid && key_in.ready));
    endtask

    // Stop offering beats and wait until every expected result is back.
    task automatic drain();
        key_in.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (2) @(posedge clk);
    endtask

    // Write all four registers on consecutive edges; only while idle.
    task automatic set_config(logic [MODE_W-1:0] mode, logic [SAMPLE_W-1:0] low,
                              logic [SAMPLE_W-1:0] high, logic [LONG_W-1:0] long_ms);
        logic [CFG_DATA_W-1:0] values [4];

        values[0] = CFG_DATA_W'(mode);
        values[1] = CFG_DATA_W'(low);
        values[2] = CFG_DATA_W'(high);
        values[3] = CFG_DATA_W'(long_ms);
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= values[i];
            @(posedge clk);
        end
        cfg_we   <= 1'b0;
        cur_mode  = mode;
        cur_low   = low;
        cur_high  = high;
        cur_long  = long_ms;
    endtask

    // Pick a raw sample that reads as the wanted level under the current mode.
    // An empty analog window reads inactive whatever the sample is.
    function automatic logic [SAMPLE_W-1:0] sample_for(logic lvl);
        logic [SAMPLE_W-1:0] raw;

        raw = SAMPLE_W'($urandom_range(0, 1023));
        case (cur_mode)
            MODE_DIRECT:   return {raw[SAMPLE_W-1:1], lvl};
            MODE_INVERTED: return {raw[SAMPLE_W-1:1], ~lvl};
            default:
            begin
                if (cur_low >= cur_high)
                    return raw;
                if (lvl)
                begin
                    // Inside the window, often on its edges.
                    case ($urandom_range(0, 3))
                        0:       return cur_low;
                        1:       return cur_high - 1'b1;
                        default: return SAMPLE_W'($urandom_range(cur_low, cur_high - 1));
                    endcase
                end
                if (cur_low > 0 && $urandom_range(0, 1) == 0)
                    return ($urandom_range(0, 1) == 0) ? cur_low - 1'b1 :
                           SAMPLE_W'($urandom_range(0, cur_low - 1));
                return ($urandom_range(0, 1) == 0) ? cur_high :
                       SAMPLE_W'($urandom_range(cur_high, 1023));
            end
        endcase
    endfunction

    // One phase: new settings, then mostly well-formed press sequences with some noise.
    task automatic run_phase(logic [MODE_W-1:0] mode, logic [SAMPLE_W-1:0] low,
                             logic [SAMPLE_W-1:0] high, logic [LONG_W-1:0] long_ms);
        logic [OP_W-1:0] op;

        set_config(mode, low, high, long_ms);
        for (int k = 0; k < ITEMS_PER_PHASE; k++)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                send(OP_W'($urandom_range(0, 7)), SAMPLE_W'($urandom_range(0, 1023)),
                     $urandom());
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    key_level = ~key_level;
                if ($urandom_range(0, 19) == 0)
                    clock_ms = clock_ms + $urandom();
                else
                    clock_ms = clock_ms + $urandom_range(0, cur_long / 2 + 3);
                op = ($urandom_range(0, 9) < 4) ? OP_EVENT : OP_W'($urandom_range(0, 7));
                send(op, sample_for(key_level), clock_ms);
            end
        end
        drain();
    endtask

    // Main sequence.
    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_SENSE_MODE;
        cfg_data          <= '0;
        key_in.valid      <= 1'b0;
        key_in.operation  <= OP_CLASSIFY;
        key_in.key_sample <= '0;
        key_in.now_ms     <= '0;
        cur_mode  = RST_SENSE_MODE;
        cur_low   = RST_WINDOW_LOW;
        cur_high  = RST_WINDOW_HIGH;
        cur_long  = RST_LONG_PRESS;
        key_level = 1'b0;
        clock_ms  = '0;
        tx_burst  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings: every operation and flag path.
        send(OP_CLASSIFY,  10'd0,    32'd0);
        send(OP_ASK_REL,   10'h3FE,  32'd5);
        send(OP_ASK_PRSNG, 10'd1,    32'd10);
        send(OP_ASK_PRSNG, 10'd1023, 32'd20);
        send(OP_ASK_PRSD,  10'd1,    32'd30);
        send(OP_ASK_RLSNG, 10'd0,    32'd40);
        send(OP_ASK_RLSNG, 10'd0,    32'd50);
        // Spare operation codes latch flags like a query but never hit.
        send(OP_SPARE_A,   10'd1,    32'd60);
        send(OP_SPARE_B,   10'd1,    32'd70);
        send(OP_ASK_PRSNG, 10'd1,    32'd80);
        send(OP_SPARE_A,   10'd0,    32'd90);
        // Elapsed time equal to the threshold is not yet a long press.
        send(OP_EVENT,     10'd1,    32'd1000);
        send(OP_EVENT,     10'd1,    32'd2000);
        send(OP_EVENT,     10'd1,    32'd2001);
        send(OP_EVENT,     10'd0,    32'd2100);
        // Short press across the wrap of the millisecond counter.
        send(OP_EVENT,     10'd1,    32'hFFFF_FF00);
        send(OP_EVENT,     10'd1,    32'h0000_0100);
        send(OP_EVENT,     10'd0,    32'h0000_0200);
        send(OP_EVENT,     10'd0,    32'hFFFF_FFFF);
        send(OP_ASK_RLSNG, 10'd0,    32'd0);
        drain();

        // Random phases over the extremes of every register, then random settings.
        run_phase(MODE_INVERTED, 10'd0,    10'd1023, 16'd0);
        run_phase(MODE_WINDOW,   10'd100,  10'd900,  16'd65535);
        run_phase(MODE_SPARE,    10'd512,  10'd513,  16'd50);
        run_phase(MODE_WINDOW,   10'd1023, 10'd0,    16'd20);
        run_phase(MODE_WINDOW,   10'd0,    10'd1023, 16'd300);
        run_phase(MODE_DIRECT,   10'd1023, 10'd1023, 16'd1);
        run_phase(MODE_WINDOW,   10'd600,  10'd600,  16'd100);
        for (int p = 0; p < 3; p++)
            run_phase(MODE_W'($urandom_range(0, 3)), SAMPLE_W'($urandom_range(0, 1023)),
                      SAMPLE_W'($urandom_range(0, 1023)),
                      ($urandom_range(0, 3) == 0) ? LONG_W'($urandom()) :
                                                    LONG_W'($urandom_range(0, 1500)));

        // Let any stray beat show up before the verdict.
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("key_edge_and_press_detector: match");
        else
            $display("key_edge_and_press_detector: mismatch");
        $finish;
    end

endmodule
